@@ hw/rtl/dcgc_pkg.sv @@
// Shared types, constants and digit-split helpers for the dual countdown game clock.
// Used by dcgc_core, dcgc_fmt and dual_countdown_game_clock; depends on nothing.
package dcgc_pkg;

	localparam int SECS_W = 13;
	localparam int SUB_W  = 16;
	localparam int CFG_W  = 16;
	localparam int IN_W   = 8;
	localparam int OUT_W  = 40;

	localparam logic [SECS_W-1:0] STARTUP_RESET = 13'd60;
	localparam logic [SUB_W-1:0]  TICKS_RESET   = 16'h3D09;

	// Register indexes on the configuration port.
	localparam logic [0:0] CFG_STARTUP = 1'b0;
	localparam logic [0:0] CFG_TICKS   = 1'b1;

	// Bit positions of the input beat.
	localparam int IN_TICK  = 0;
	localparam int IN_LEFT  = 1;
	localparam int IN_RIGHT = 2;
	localparam int IN_START = 3;

	// floor(x * RECIP60 / 2^20) equals x / 60 for every 13-bit x.
	localparam logic [14:0] RECIP60 = 15'd17477;
	// floor(x * RECIP10 / 2^11) equals x / 10 for every 8-bit x.
	localparam logic [7:0]  RECIP10 = 8'd205;

	typedef struct packed {
		logic [SECS_W-1:0] left_secs;
		logic [SECS_W-1:0] right_secs;
		logic              running;
		logic              left_turn;
		logic              expired;
	} snap_t;

	typedef struct packed {
		logic [7:0] mins;
		logic [5:0] secs;
	} mmss_t;

	typedef struct packed {
		mmss_t left;
		mmss_t right;
		logic  running;
		logic  left_turn;
		logic  expired;
	} split_t;

	typedef struct packed {
		logic [3:0] sec_units;
		logic [2:0] sec_tens;
		logic [3:0] min_units;
		logic [3:0] min_tens;
	} digits_t;

	typedef struct packed {
		digits_t left;
		digits_t right;
		logic    running;
		logic    left_turn;
		logic    expired;
	} disp_t;

	// Splits a second count into minutes and the remaining seconds.
	function automatic mmss_t div60(input logic [SECS_W-1:0] total);
		logic [27:0] prod;
		logic [7:0]  mins;
		logic [13:0] mins60;
		logic [13:0] rem;
		mmss_t       res;
		prod   = 28'(total) * 28'(RECIP60);
		mins   = prod[27:20];
		mins60 = {mins, 6'b0} - {4'b0, mins, 2'b0};
		rem    = {1'b0, total} - mins60;
		res.mins = mins;
		res.secs = rem[5:0];
		return res;
	endfunction

	// Returns {tens[3:0], units[3:0]} of an 8-bit value; tens wraps at 16.
	function automatic logic [7:0] div10(input logic [7:0] val);
		logic [15:0] prod;
		logic [4:0]  quot;
		logic [7:0]  quot10;
		logic [7:0]  units;
		prod   = 16'(val) * 16'(RECIP10);
		quot   = prod[15:11];
		quot10 = {quot, 3'b0} + {2'b0, quot, 1'b0};
		units  = val - quot10;
		return {quot[3:0], units[3:0]};
	endfunction

	function automatic digits_t to_digits(input mmss_t t);
		logic [7:0] m;
		logic [7:0] s;
		digits_t    d;
		m = div10(t.mins);
		s = div10({2'b0, t.secs});
		d.min_tens  = m[7:4];
		d.min_units = m[3:0];
		d.sec_tens  = s[6:4];
		d.sec_units = s[3:0];
		return d;
	endfunction

endpackage

@@ hw/rtl/dcgc_core.sv @@
// Clock state, button edge handling and configuration registers of the game clock.
// Depends on dcgc_pkg; feeds a snapshot of both clocks to dcgc_fmt.
module dcgc_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [dcgc_pkg::IN_W-1:0]    s_tdata,
	input  logic                         cfg_we,
	input  logic [0:0]                   cfg_index,
	input  logic [dcgc_pkg::CFG_W-1:0]   cfg_data,
	output logic                         s1_valid,
	input  logic                         s1_ready,
	output dcgc_pkg::snap_t              s1_snap
);

	logic [dcgc_pkg::SECS_W-1:0] startup_q;
	logic [dcgc_pkg::SUB_W-1:0]  tps_q;

	logic [dcgc_pkg::SECS_W-1:0] left_secs_q, right_secs_q;
	logic [dcgc_pkg::SUB_W-1:0]  sub_q, left_save_q, right_save_q;
	logic                        running_q, left_turn_q;
	logic [2:0]                  prev_q;

	logic [dcgc_pkg::SECS_W-1:0] left_secs_d, right_secs_d;
	logic [dcgc_pkg::SUB_W-1:0]  sub_d, left_save_d, right_save_d, sub_inc;
	logic                        running_d, left_turn_d;
	logic [2:0]                  btns, edges;

	logic                        s1_valid_q;
	dcgc_pkg::snap_t             snap_s1;
	logic                        accept;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !s1_valid_q || s1_ready;
	assign s1_valid = s1_valid_q;
	assign s1_snap  = snap_s1;

	assign btns  = {s_tdata[dcgc_pkg::IN_START], s_tdata[dcgc_pkg::IN_RIGHT],
		s_tdata[dcgc_pkg::IN_LEFT]};
	assign edges = btns & ~prev_q;

	// Presses are applied in the order left, right, start, then the tick.
	always_comb begin
		left_secs_d  = left_secs_q;
		right_secs_d = right_secs_q;
		sub_d        = sub_q;
		left_save_d  = left_save_q;
		right_save_d = right_save_q;
		running_d    = running_q;
		left_turn_d  = left_turn_q;
		sub_inc      = '0;
		if (edges[0]) begin
			left_turn_d  = 1'b1;
			right_save_d = sub_d;
			sub_d        = left_save_d;
		end
		if (edges[1]) begin
			left_turn_d = 1'b0;
			left_save_d = sub_d;
			sub_d       = right_save_d;
		end
		if (edges[2]) begin
			if (left_secs_d == '0 || right_secs_d == '0) begin
				left_secs_d  = startup_q;
				right_secs_d = startup_q;
				running_d    = 1'b0;
			end else begin
				running_d = !running_d;
			end
		end
		if (s_tdata[dcgc_pkg::IN_TICK]) begin
			sub_inc = sub_d + 16'd1;
			if (sub_inc == tps_q) begin
				sub_d = '0;
				if (running_d && left_secs_d != '0 && right_secs_d != '0) begin
					if (left_turn_d) begin
						left_secs_d = left_secs_d - 13'd1;
					end else begin
						right_secs_d = right_secs_d - 13'd1;
					end
				end
			end else begin
				sub_d = sub_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			startup_q    <= dcgc_pkg::STARTUP_RESET;
			tps_q        <= dcgc_pkg::TICKS_RESET;
			left_secs_q  <= dcgc_pkg::STARTUP_RESET;
			right_secs_q <= dcgc_pkg::STARTUP_RESET;
			sub_q        <= '0;
			left_save_q  <= '0;
			right_save_q <= '0;
			running_q    <= 1'b0;
			left_turn_q  <= 1'b1;
			prev_q       <= '0;
			s1_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					dcgc_pkg::CFG_STARTUP: startup_q <= cfg_data[dcgc_pkg::SECS_W-1:0];
					dcgc_pkg::CFG_TICKS:   tps_q     <= cfg_data[dcgc_pkg::SUB_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				left_secs_q  <= left_secs_d;
				right_secs_q <= right_secs_d;
				sub_q        <= sub_d;
				left_save_q  <= left_save_d;
				right_save_q <= right_save_d;
				running_q    <= running_d;
				left_turn_q  <= left_turn_d;
				prev_q       <= btns;
				s1_valid_q   <= 1'b1;
			end else if (s1_ready) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	// Snapshot of the clocks after this beat; payload only, no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			snap_s1.left_secs  <= left_secs_d;
			snap_s1.right_secs <= right_secs_d;
			snap_s1.running    <= running_d;
			snap_s1.left_turn  <= left_turn_d;
			snap_s1.expired    <= (left_secs_d == '0) || (right_secs_d == '0);
		end
	end

	a_left_press: assert property (@(posedge clk) disable iff (!arst_n)
		accept && edges[0] && !edges[1] |=> left_turn_q)
		else $error("left press did not give the turn to the left side");

	a_secs_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(left_secs_q) && $stable(right_secs_q))
		else $error("clock seconds changed without an accepted beat");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !edges[2] |=> $stable(left_secs_q) || $stable(right_secs_q))
		else $error("both clocks changed on one beat without a start press");

endmodule

@@ hw/rtl/dcgc_fmt.sv @@
// Two-stage MM:SS digit split with an elastic handshake per stage.
// Depends on dcgc_pkg; its last stage is the output register of the game clock.
module dcgc_fmt (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s1_valid,
	output logic             s1_ready,
	input  dcgc_pkg::snap_t  s1_snap,
	output logic             out_valid,
	input  logic             out_ready,
	output dcgc_pkg::disp_t  out_disp
);

	logic             s2_valid_q, s3_valid_q;
	logic             s2_ready, s3_ready;
	dcgc_pkg::split_t split_s2;
	dcgc_pkg::disp_t  disp_s3;

	assign s3_ready  = !s3_valid_q || out_ready;
	assign s2_ready  = !s2_valid_q || s3_ready;
	assign s1_ready  = s2_ready;
	assign out_valid = s3_valid_q;
	assign out_disp  = disp_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
			s3_valid_q <= 1'b0;
		end else begin
			if (s2_ready) begin
				s2_valid_q <= s1_valid;
			end
			if (s3_ready) begin
				s3_valid_q <= s2_valid_q;
			end
		end
	end

	// Minutes and seconds by reciprocal multiplication.
	always_ff @(posedge clk) begin
		if (s2_ready && s1_valid) begin
			split_s2.left      <= dcgc_pkg::div60(s1_snap.left_secs);
			split_s2.right     <= dcgc_pkg::div60(s1_snap.right_secs);
			split_s2.running   <= s1_snap.running;
			split_s2.left_turn <= s1_snap.left_turn;
			split_s2.expired   <= s1_snap.expired;
		end
	end

	// Decimal digits of minutes and seconds.
	always_ff @(posedge clk) begin
		if (s3_ready && s2_valid_q) begin
			disp_s3.left      <= dcgc_pkg::to_digits(split_s2.left);
			disp_s3.right     <= dcgc_pkg::to_digits(split_s2.right);
			disp_s3.running   <= split_s2.running;
			disp_s3.left_turn <= split_s2.left_turn;
			disp_s3.expired   <= split_s2.expired;
		end
	end

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q |-> split_s2.left.secs < 6'd60 && split_s2.right.secs < 6'd60)
		else $error("seconds remainder out of range");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		s3_valid_q |-> disp_s3.left.sec_tens <= 3'd5 && disp_s3.right.sec_tens <= 3'd5
			&& disp_s3.left.sec_units <= 4'd9 && disp_s3.right.sec_units <= 4'd9
			&& disp_s3.left.min_units <= 4'd9 && disp_s3.right.min_units <= 4'd9)
		else $error("decimal digit out of range");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		s3_valid_q && !out_ready |=> s3_valid_q)
		else $error("held display beat was dropped");

endmodule

@@ hw/rtl/dual_countdown_game_clock.sv @@
// Top level of the dual countdown game clock (chess clock with MM:SS digits).
// Depends on dcgc_pkg, dcgc_core and dcgc_fmt.
//
//  Channel   Dir  Handshake           Payload
//  s_*       in   s_tvalid/s_tready   s_tdata[7:0]: one sample (tick, buttons)
//  m_*       out  m_tvalid/m_tready   m_tdata[39:0]: both clocks as digits, flags
//  cfg_*     in   cfg_we              cfg_index[0:0], cfg_data[15:0]
//
// One sample beat is taken per clock cycle while s_tready is high, and each
// yields exactly one display beat. The clock state is updated in the cycle a
// sample is accepted; the digit split follows in two more register stages.
// The throughput is set by the state update, which holds a 16-bit increment
// and compare in front of the state registers.
// Reset loads both clocks with 60 seconds, the tick target with 15625, and the
// left side as active; no memory needs a clearing pass.
// Each of the three stages has its own valid bit, so a stalled output still lets
// samples flow into empty stages; up to three results are held during a stall.
module dual_countdown_game_clock (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// s_tdata from bit 0: tick, left_button, right_button, start_button, zero pad.
	input  logic [dcgc_pkg::IN_W-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// m_tdata from bit 0: left_min_tens(4), left_min_units(4), left_sec_tens(3),
	// left_sec_units(4), right_min_tens(4), right_min_units(4), right_sec_tens(3),
	// right_sec_units(4), running_flag, left_turn_flag, expired_flag, zero pad.
	output logic [dcgc_pkg::OUT_W-1:0]  m_tdata,
	input  logic                        cfg_we,
	input  logic [0:0]                  cfg_index,
	input  logic [dcgc_pkg::CFG_W-1:0]  cfg_data
);

	logic            s1_valid, s1_ready;
	dcgc_pkg::snap_t s1_snap;
	dcgc_pkg::disp_t disp;

	// The core owns the clock state and the configuration registers.
	dcgc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s1_valid  (s1_valid),
		.s1_ready  (s1_ready),
		.s1_snap   (s1_snap)
	);

	// The formatter turns second counts into decimal digits.
	dcgc_fmt u_fmt (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (s1_valid),
		.s1_ready  (s1_ready),
		.s1_snap   (s1_snap),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_disp  (disp)
	);

	// Pack the result beat, first field in the lowest bits.
	assign m_tdata = {7'b0,
		disp.expired, disp.left_turn, disp.running,
		disp.right.sec_units, disp.right.sec_tens,
		disp.right.min_units, disp.right.min_tens,
		disp.left.sec_units, disp.left.sec_tens,
		disp.left.min_units, disp.left.min_tens};

endmodule
